### src/aesd_pkg.sv
// shared types and constants of the archive entry stream decryptor
`default_nettype none

package aesd_pkg;

  // key schedule: key advances as key * 7 + 3 every four bytes
  localparam logic [31:0] KEY_MUL = 32'd7;
  localparam logic [31:0] KEY_ADD = 32'd3;

  // jump-ahead walks the bits of position / 4
  localparam int unsigned STEP_W = 30;

  // operation codes carried in tuser
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_SEEK  = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;

  // seek origin codes
  localparam logic [1:0] ORG_START = 2'd0;
  localparam logic [1:0] ORG_CUR   = 2'd1;

  // configuration register indexes
  localparam logic CFG_BASE_KEY  = 1'b0;
  localparam logic CFG_ENTRY_LEN = 1'b1;

  // request from the control path to the jump-ahead sequencer
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } jump_req_t;

  // answer of the jump-ahead sequencer
  typedef struct packed {
    logic        done;
    logic [31:0] key;
  } jump_rsp_t;

endpackage

`default_nettype wire

### src/aesd_mul.sv
// shared 32-bit multiply-add unit, low half of the product
`default_nettype none

module aesd_mul (
  input  logic [31:0] mul_a_i,
  input  logic [31:0] mul_b_i,
  input  logic [31:0] add_i,
  output logic [31:0] res_o
);

  logic [63:0] prod;

  // product wraps modulo 2^32 like the key arithmetic
  assign prod  = mul_a_i * mul_b_i;
  assign res_o = prod[31:0] + add_i;

endmodule

`default_nettype wire

### src/aesd_jump.sv
// affine jump-ahead of the running key over position / 4 steps
`default_nettype none

module aesd_jump
  import aesd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  jump_req_t   req_i,
  input  logic [31:0] key_i,
  output jump_rsp_t   rsp_o
);

  typedef enum logic [1:0] {
    J_IDLE,
    J_KEY,
    J_B,
    J_A
  } jump_state_e;

  jump_state_e       state_q;
  logic              done_q;
  logic [31:0]       k_q;
  logic [31:0]       a_q;
  logic [31:0]       b_q;
  logic [STEP_W-1:0] steps_q;

  logic [31:0] op_x;
  logic [31:0] op_y;
  logic [31:0] op_z;
  logic [31:0] mul_res;

  // operand selection for the shared multiplier
  always_comb begin
    op_x = '0;
    op_y = '0;
    op_z = '0;
    case (state_q)
      J_KEY: begin
        if (steps_q[0]) begin
          op_x = k_q;
          op_y = a_q;
          op_z = b_q;
        end else begin
          op_x = b_q;
          op_y = a_q + 32'd1;
        end
      end
      J_B: begin
        op_x = b_q;
        op_y = a_q + 32'd1;
      end
      J_A: begin
        op_x = a_q;
        op_y = a_q;
      end
      default: begin
        op_x = '0;
      end
    endcase
  end

  aesd_mul u_mul (
    .mul_a_i (op_x),
    .mul_b_i (op_y),
    .add_i   (op_z),
    .res_o   (mul_res)
  );

  // sequencer: per bit apply k when the bit is set, then square the step pair (b first, a last)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= J_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        J_IDLE: begin
          if (req_i.start) begin
            k_q     <= key_i;
            a_q     <= KEY_MUL;
            b_q     <= KEY_ADD;
            steps_q <= req_i.steps;
            if (req_i.steps == '0) begin
              done_q <= 1'b1;
            end else begin
              state_q <= J_KEY;
            end
          end
        end
        J_KEY: begin
          if (steps_q[0]) begin
            k_q <= mul_res;
            if (steps_q[STEP_W-1:1] == '0) begin
              done_q  <= 1'b1;
              state_q <= J_IDLE;
            end else begin
              state_q <= J_B;
            end
          end else begin
            b_q     <= mul_res;
            state_q <= J_A;
          end
        end
        J_B: begin
          b_q     <= mul_res;
          state_q <= J_A;
        end
        J_A: begin
          a_q     <= mul_res;
          steps_q <= steps_q >> 1;
          state_q <= J_KEY;
        end
        default: begin
          state_q <= J_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.key  = k_q;

endmodule

`default_nettype wire

### src/archive_entry_stream_decrypt.sv
// top level of the archive entry stream decryptor
//
//  channel   dir  handshake                     contents
//  s_axis    in   s_axis_tvalid/s_axis_tready   func in tuser; byte, offset, origin in tdata
//  m_axis    out  m_axis_tvalid/m_axis_tready   plain byte, position in tdata; past_end in tuser
//  cfg       in   cfg_we_i                      base key (0), entry length (1)
//
// read, start, no-op and a seek that keeps the position: result in the cycle after accept
// a seek that moves the position: result once the jump-ahead is done; it walks the bits
// of position / 4, the shared 32-bit multiplier doing key, step and square updates
// reset clears position, keys, entry length, state and output valid at once; there is no clearing pass
// a new word is taken while a result waits, if the next result slot frees in that cycle
// input is held off while a jump-ahead runs or a result waits without being taken
`default_nettype none

module archive_entry_stream_decrypt
  import aesd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // cipher_byte, seek_offset, seek_origin, zero pad
  input  logic [1:0]  s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // plain_byte, position
  output logic [0:0]  m_axis_tuser,   // past_end
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  typedef enum logic {
    S_IDLE,
    S_SEEK
  } top_state_e;

  top_state_e  state_q;
  logic [31:0] key_q;
  logic [31:0] len_q;
  logic [31:0] rkey_q;
  logic [31:0] pos_q;
  logic [31:0] pend_q;
  logic        out_valid_q;
  logic [39:0] out_data_q;
  logic        out_user_q;

  jump_req_t jreq;
  jump_rsp_t jrsp;

  logic               accept;
  logic [1:0]         func;
  logic [7:0]         cbyte;
  logic signed [33:0] off;
  logic [1:0]         origin;
  logic [7:0]         key_byte;
  logic [31:0]        pos_inc;
  logic [31:0]        key_adv;
  logic               at_end;
  logic [35:0]        base_w;
  logic [35:0]        sum_w;
  logic [31:0]        seek_pos;

  // input word fields
  assign func   = s_axis_tuser;
  assign cbyte  = s_axis_tdata[7:0];
  assign off    = s_axis_tdata[41:8];
  assign origin = s_axis_tdata[43:42];

  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // read path: key byte by position modulo 4, key advance by shift and subtract
  assign key_byte = rkey_q[{pos_q[1:0], 3'b000} +: 8];
  assign pos_inc  = pos_q + 32'd1;
  assign key_adv  = {rkey_q[28:0], 3'b000} - rkey_q + KEY_ADD;
  assign at_end   = pos_q >= len_q;

  // seek target, clamped to 0 .. entry length
  always_comb begin
    case (origin)
      ORG_START: base_w = '0;
      ORG_CUR:   base_w = {4'b0000, pos_q};
      default:   base_w = {4'b0000, len_q};
    endcase
    sum_w = base_w + {{2{off[33]}}, off};
    if (sum_w[35]) begin
      seek_pos = '0;
    end else if (sum_w[34:0] > {3'b000, len_q}) begin
      seek_pos = len_q;
    end else begin
      seek_pos = sum_w[31:0];
    end
  end

  // jump-ahead request
  assign jreq.start = accept && (func == FUNC_SEEK) && (seek_pos != pos_q);
  assign jreq.steps = seek_pos[31:2];

  aesd_jump u_jump (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (jreq),
    .key_i  (key_q),
    .rsp_o  (jrsp)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      len_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE_KEY:  key_q <= cfg_wdata_i;
        CFG_ENTRY_LEN: len_q <= cfg_wdata_i;
        default:       key_q <= key_q;
      endcase
    end
  end

  // control, stream state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      rkey_q      <= '0;
      pos_q       <= '0;
    end else begin
      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            out_valid_q <= 1'b1;
            out_user_q  <= 1'b0;
            out_data_q  <= {pos_q, 8'h00};
            case (func)
              FUNC_READ: begin
                if (at_end) begin
                  out_user_q <= 1'b1;
                end else begin
                  out_data_q <= {pos_inc, cbyte ^ key_byte};
                  pos_q      <= pos_inc;
                  if (pos_inc[1:0] == 2'b00) begin
                    rkey_q <= key_adv;
                  end
                end
              end
              FUNC_SEEK: begin
                if (seek_pos != pos_q) begin
                  out_valid_q <= 1'b0;
                  pend_q      <= seek_pos;
                  state_q     <= S_SEEK;
                end
              end
              FUNC_START: begin
                rkey_q     <= key_q;
                pos_q      <= '0;
                out_data_q <= '0;
              end
              default: begin
                out_user_q <= 1'b0;
              end
            endcase
          end
        end
        S_SEEK: begin
          if (jrsp.done) begin
            rkey_q      <= jrsp.key;
            pos_q       <= pend_q;
            out_data_q  <= {pend_q, 8'h00};
            out_user_q  <= 1'b0;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_user_q;

  // jump-ahead only finishes while a seek is pending
  a_done_in_seek: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jrsp.done |-> (state_q == S_SEEK))
    else $error("jump-ahead finished outside a seek");

  // a new result appears only after an accept or a finished jump
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> ($past(accept) || $past(jrsp.done)))
    else $error("result word without a cause");

  // a seek that moves starts the jump and leaves the output slot empty
  a_seek_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jreq.start |=> (state_q == S_SEEK) && !out_valid_q)
    else $error("seek did not enter the jump-ahead wait");

endmodule

`default_nettype wire
